@@ sv/sorted_score_open_list_unit_assert.svh @@
// Assertion macros for the sorted score open list unit.
`ifndef SORTED_SCORE_OPEN_LIST_UNIT_ASSERT_SVH
`define SORTED_SCORE_OPEN_LIST_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSOL_ASSERT_ALWAYS(label, clock, rstn, expr) \
	label: assert property (@(posedge clock) disable iff (!rstn) (expr)) \
		else $error("open list assertion failed");
`define SSOL_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("open list assertion failed");
`else
`define SSOL_ASSERT_ALWAYS(label, clock, rstn, expr)
`define SSOL_ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif
`endif

@@ sv/ssol_pkg.sv @@
// Types and constants shared by the sorted score open list unit.
`timescale 1ns / 1ps
`default_nettype none
package ssol_pkg;

	localparam int ID_W    = 16;
	localparam int SCORE_W = 16;
	localparam int POS_W   = 10;
	localparam int CNT_W   = 11;
	localparam int ENTRY_W = ID_W + SCORE_W;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_ADJUST = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_NOT_LOWER = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_SEARCH_CMP,
		S_BACK,
		S_BACK_CMP,
		S_FWD,
		S_FWD_CMP,
		S_CHECK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PLACE,
		S_FINISH
	} ssol_state_t;

	typedef enum logic [1:0] {
		PH_INSERT,
		PH_OLD,
		PH_NEW
	} ssol_phase_t;

endpackage
`default_nettype wire

@@ sv/sorted_score_open_list_unit.sv @@
// Sorted score open list: request handling, binary search and table shifting.
// Usage notes.
// Input channel: in_valid/in_stall carries one request (operation, node_id,
// score, old_score). Insert (operation 0) adds a node; adjust (operation 1)
// lowers a held node's score and moves it towards the end of the table.
// Output channel: out_valid/out_stall returns one result per request
// (status, position, entry_count), in request order.
// One request is worked on at a time; in_stall is high while it is busy.
// Each probe of a binary search reads the table memory in S_SEARCH and
// compares the registered read data in S_SEARCH_CMP. Every entry moved
// by a shift is read in S_SHIFT_RD and written back one place over in
// S_SHIFT_WR, so an insert at the front of a nearly full table moves most.
// Adjust runs two searches plus a scan over equal scores around the node.
// Requests that fail a simple check (list full, score not lower) go
// straight from idle to S_FINISH. Table memory read data is registered.
// Reset empties the list at once; no clearing pass is needed.
// While the receiver stalls, the result is held, and the next request is
// still accepted; it completes once the held result has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_score_open_list_unit_assert.svh"
module sorted_score_open_list_unit #(
	parameter int CAPACITY = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        operation,
	input  wire logic [ssol_pkg::ID_W-1:0]    node_id,
	input  wire logic [ssol_pkg::SCORE_W-1:0] score,
	input  wire logic [ssol_pkg::SCORE_W-1:0] old_score,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       status,
	output logic [ssol_pkg::POS_W-1:0]        position,
	output logic [ssol_pkg::CNT_W-1:0]        entry_count
);
	import ssol_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	// Table memory: node id in the upper half, score in the lower half.
	logic [ENTRY_W-1:0] mem [CAPACITY];
	logic [ENTRY_W-1:0] rd_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	ssol_state_t state_q, state_d;
	ssol_phase_t phase_q;
	logic [CW-1:0] count_q;
	logic          adj_q;
	logic [ID_W-1:0]    id_q;
	logic [SCORE_W-1:0] score_q, old_q;
	logic [CW-1:0] lower_q, upper_q, mid_q, p_q, q_q, it_q, j_q, at_q, sh_q, res_pos_q;
	logic          last_q, up_q;
	logic [1:0]    res_status_q;
	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [CW-1:0] out_pos_q, out_count_q;

	logic [CW-1:0]      mid;
	logic               srch_last;
	logic [SCORE_W-1:0] skey, cmp_score;
	logic [ID_W-1:0]    cmp_id;
	logic               srch_done;
	logic [CW-1:0]      srch_res;
	logic               id_hit, score_eq, back_break, fwd_ok;
	logic [CW-1:0]      place_pos;
	logic               accept, out_free;

	// Memory ports, one read and one write, read data registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	// Shared search and compare terms.
	assign mid       = lower_q + ((upper_q - lower_q) >> 1);
	assign srch_last = !(upper_q > lower_q + ONE_C);
	assign skey      = (phase_q == PH_OLD) ? old_q : score_q;
	assign cmp_score = rd_data[SCORE_W-1:0];
	assign cmp_id    = rd_data[ENTRY_W-1:SCORE_W];
	assign srch_done = last_q || (cmp_score == skey);
	assign srch_res  = last_q ? ((cmp_score <= skey) ? lower_q : upper_q) : mid_q;
	assign id_hit    = (cmp_id == id_q);
	assign score_eq  = (cmp_score == old_q);
	assign back_break = !score_eq || (it_q == '0);
	assign fwd_ok    = (it_q == p_q) ? score_eq : 1'b1;
	assign place_pos = adj_q ? (q_q - ONE_C) : p_q;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign position    = POS_W'(out_pos_q);
	assign entry_count = CNT_W'(out_count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_INSERT) begin
						if (count_q >= CAP_C) state_d = S_FINISH;
						else if (count_q == '0) state_d = S_PLACE;
						else state_d = S_SEARCH;
					end else begin
						if (score >= old_score || count_q == '0) state_d = S_FINISH;
						else state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: state_d = S_SEARCH_CMP;
			S_SEARCH_CMP: begin
				if (!srch_done) begin
					state_d = S_SEARCH;
				end else begin
					unique case (phase_q)
						PH_INSERT: state_d = (srch_res < count_q) ? S_SHIFT_RD : S_PLACE;
						PH_OLD:    state_d = (srch_res >= count_q) ? S_FINISH : S_SEARCH;
						PH_NEW:    state_d = S_BACK;
						default:   state_d = S_FINISH;
					endcase
				end
			end
			S_BACK: state_d = S_BACK_CMP;
			S_BACK_CMP: begin
				if (id_hit) state_d = S_CHECK;
				else if (back_break) state_d = fwd_ok ? S_FWD : S_FINISH;
				else state_d = S_BACK;
			end
			S_FWD: state_d = (j_q >= count_q) ? S_FINISH : S_FWD_CMP;
			S_FWD_CMP: begin
				if (id_hit) state_d = S_CHECK;
				else if (!score_eq) state_d = S_FINISH;
				else state_d = S_FWD;
			end
			S_CHECK: begin
				if (q_q <= at_q) state_d = S_FINISH;
				else if (q_q - at_q > ONE_C) state_d = S_SHIFT_RD;
				else state_d = S_PLACE;
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: begin
				if (up_q) state_d = (sh_q == p_q) ? S_PLACE : S_SHIFT_RD;
				else state_d = (sh_q + ONE_C == q_q - ONE_C) ? S_PLACE : S_SHIFT_RD;
			end
			S_PLACE:  state_d = S_FINISH;
			S_FINISH: state_d = out_free ? S_IDLE : S_FINISH;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory control per state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		unique case (state_q)
			S_SEARCH: begin
				rd_en   = 1'b1;
				rd_addr = srch_last ? AW'(lower_q) : AW'(mid);
			end
			S_BACK: begin
				rd_en   = 1'b1;
				rd_addr = AW'(it_q);
			end
			S_FWD: begin
				rd_en   = (j_q < count_q);
				rd_addr = AW'(j_q);
			end
			S_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_addr = up_q ? AW'(sh_q) : AW'(sh_q + ONE_C);
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = up_q ? AW'(sh_q + ONE_C) : AW'(sh_q);
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = AW'(place_pos);
				wr_data = {id_q, score_q};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PLACE && !adj_q) begin
				count_q <= count_q + ONE_C;
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					id_q      <= node_id;
					score_q   <= score;
					old_q     <= old_score;
					adj_q     <= (operation == OP_ADJUST);
					phase_q   <= (operation == OP_ADJUST) ? PH_OLD : PH_INSERT;
					lower_q   <= '0;
					upper_q   <= count_q;
					p_q       <= '0;
					res_pos_q <= '0;
					if (operation == OP_INSERT) res_status_q <= ST_FULL;
					else if (score >= old_score) res_status_q <= ST_NOT_LOWER;
					else res_status_q <= ST_NOT_FOUND;
				end
			end
			S_SEARCH: begin
				mid_q  <= mid;
				last_q <= srch_last;
			end
			S_SEARCH_CMP: begin
				if (!srch_done) begin
					if (cmp_score < skey) upper_q <= mid_q;
					else lower_q <= mid_q;
				end else begin
					case (phase_q)
						PH_INSERT: begin
							p_q  <= srch_res;
							sh_q <= count_q - ONE_C;
							up_q <= 1'b1;
						end
						PH_OLD: begin
							p_q     <= srch_res;
							phase_q <= PH_NEW;
							lower_q <= '0;
							upper_q <= count_q;
						end
						default: begin
							q_q  <= srch_res;
							it_q <= p_q;
						end
					endcase
				end
			end
			S_BACK_CMP: begin
				if (id_hit) at_q <= it_q;
				else if (back_break) j_q <= p_q + ONE_C;
				else it_q <= it_q - ONE_C;
			end
			S_FWD_CMP: begin
				if (id_hit) at_q <= j_q;
				else j_q <= j_q + ONE_C;
			end
			S_CHECK: begin
				res_status_q <= ST_NOT_LOWER;
				sh_q <= at_q;
				up_q <= 1'b0;
			end
			S_SHIFT_WR: begin
				sh_q <= up_q ? (sh_q - ONE_C) : (sh_q + ONE_C);
			end
			S_PLACE: begin
				res_status_q <= ST_OK;
				res_pos_q    <= place_pos;
			end
			default: begin
			end
		endcase
	end

	// Result register towards the receiver.
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
			out_count_q  <= count_q;
		end
	end

	// Checks on the list bookkeeping.
	`SSOL_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CAP_C)
	`SSOL_ASSERT_NEXT(a_insert_grows, clk, arst_n, state_q == S_PLACE && !adj_q,
		count_q == $past(count_q) + ONE_C)
	`SSOL_ASSERT_NEXT(a_count_hold, clk, arst_n, state_q != S_PLACE,
		count_q == $past(count_q))
	`SSOL_ASSERT_ALWAYS(a_search_range, clk, arst_n,
		state_q != S_SEARCH_CMP || upper_q <= count_q)

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the sorted score open list unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import ssol_pkg::*;

	localparam int DEPTH = 1024;
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct {
		logic       op;
		logic [15:0] id;
		logic [15:0] sc;
		logic [15:0] old;
		bit         typed;
		logic [1:0] st;
		logic [9:0] pos;
		logic [10:0] cnt;
	} table_row_t;

	typedef struct {
		logic [1:0]  st;
		logic [9:0]  pos;
		logic [10:0] cnt;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [15:0] node_id;
	logic [15:0] score;
	logic [15:0] old_score;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [9:0]  position;
	logic [10:0] entry_count;

	// Shadow copy of the open list.
	logic [15:0] shadow_ids [DEPTH];
	logic [15:0] shadow_scores [DEPTH];
	int          shadow_count;

	list_result_t pending_results[$];
	table_row_t   directed_rows[$];
	int  error_count;
	int  idle_cycles;
	int  results_seen;
	int  inserts_sent;
	int  adjusts_sent;
	bit  calm;

	sorted_score_open_list_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .node_id(node_id), .score(score), .old_score(old_score),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .position(position), .entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Binary search for the slot that a score selects in the descending table.
	function automatic int find_slot(input logic [15:0] key);
		int lower;
		int upper;
		int mid;
		lower = 0;
		upper = shadow_count;
		if (upper == 0)
			return shadow_count;
		while (upper > lower + 1) begin
			mid = lower + (upper - lower) / 2;
			if (shadow_scores[mid] < key)
				upper = mid;
			else if (shadow_scores[mid] > key)
				lower = mid;
			else
				return mid;
		end
		return (shadow_scores[lower] <= key) ? lower : upper;
	endfunction

	// Look for the node backwards through equal scores, then forwards; -1 if absent.
	function automatic int find_node(input logic [15:0] id, input logic [15:0] old, input int start);
		int it;
		it = start;
		forever begin
			if (shadow_ids[it] == id)
				return it;
			if (shadow_scores[it] != old || it == 0)
				break;
			it--;
		end
		it = start;
		forever begin
			if (it >= shadow_count || shadow_scores[it] != old)
				return -1;
			it++;
			if (it < shadow_count && shadow_ids[it] == id)
				return it;
		end
	endfunction

	// Apply one request to the shadow list and return the result it should give.
	function automatic list_result_t apply_request(input logic op, input logic [15:0] id,
			input logic [15:0] sc, input logic [15:0] old);
		list_result_t r;
		int p;
		int q;
		int at;
		r.st = ST_OK;
		r.pos = '0;
		if (op == OP_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				p = find_slot(sc);
				for (int i = shadow_count; i > p; i--) begin
					shadow_ids[i] = shadow_ids[i-1];
					shadow_scores[i] = shadow_scores[i-1];
				end
				shadow_ids[p] = id;
				shadow_scores[p] = sc;
				shadow_count++;
				r.pos = p[9:0];
			end
		end else if (sc >= old) begin
			r.st = ST_NOT_LOWER;
		end else begin
			p = find_slot(old);
			q = find_slot(sc);
			at = (p >= shadow_count) ? -1 : find_node(id, old, p);
			if (at < 0) begin
				r.st = ST_NOT_FOUND;
			end else if (q <= at) begin
				r.st = ST_NOT_LOWER;
			end else begin
				for (int i = at; i < q - 1; i++) begin
					shadow_ids[i] = shadow_ids[i+1];
					shadow_scores[i] = shadow_scores[i+1];
				end
				shadow_ids[q-1] = id;
				shadow_scores[q-1] = sc;
				r.pos = 10'(q - 1);
			end
		end
		r.cnt = shadow_count[10:0];
		return r;
	endfunction

	// Offer one request, at times with a random gap first, and wait until it is taken.
	task automatic send_request(input logic op, input logic [15:0] id, input logic [15:0] sc,
			input logic [15:0] old, input bit typed, input list_result_t typed_result);
		list_result_t predicted;
		predicted = apply_request(op, id, sc, old);
		pending_results.push_back(typed ? typed_result : predicted);
		if (op == OP_INSERT)
			inserts_sent++;
		else
			adjusts_sent++;
		if (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		node_id   <= id;
		score     <= sc;
		old_score <= old;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Random adjust: mostly a held node lowered, sometimes noise.
	task automatic send_random_adjust();
		int idx;
		logic [15:0] old;
		list_result_t unused;
		unused = '{default: '0};
		if (shadow_count > 0 && $urandom_range(99) < 80) begin
			idx = $urandom_range(shadow_count - 1);
			old = shadow_scores[idx];
			if (old == 0)
				send_request(OP_ADJUST, shadow_ids[idx], 16'($urandom_range(65535)), old, 0, unused);
			else if ($urandom_range(9) == 0)
				send_request(OP_ADJUST, shadow_ids[idx], 16'd0, old, 0, unused);
			else
				send_request(OP_ADJUST, shadow_ids[idx],
					16'($urandom_range(old / 2, old - 1)), old, 0, unused);
		end else begin
			send_request(OP_ADJUST, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 0, unused);
		end
	endtask

	// Receiver: random stall, and compare each result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result status=%0d position=%0d entry_count=%0d",
						$time, status, position, entry_count);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.st) begin
						error_count++;
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					end
					if (position !== want.pos) begin
						error_count++;
						$display("%0t: position expected %0d actual %0d", $time, want.pos,
							position);
					end
					if (entry_count !== want.cnt) begin
						error_count++;
						$display("%0t: entry_count expected %0d actual %0d", $time, want.cnt,
							entry_count);
					end
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 36);
		end
	end

	// Watchdog on cycles in which neither channel moves a request or result.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus: directed table, then a random mix of inserts and adjusts.
	initial begin
		list_result_t typed_result;
		list_result_t unused;
		table_row_t row;
		int n;
		unused = '{default: '0};
		error_count = 0;
		idle_cycles = 0;
		results_seen = 0;
		inserts_sent = 0;
		adjusts_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_INSERT;
		node_id = '0;
		score = '0;
		old_score = '0;
		shadow_count = 0;
		directed_rows = '{
			'{OP_ADJUST, 16'd5, 16'd10, 16'd20, 1, ST_NOT_FOUND, 10'd0, 11'd0},
			'{OP_ADJUST, 16'd5, 16'd20, 16'd20, 1, ST_NOT_LOWER, 10'd0, 11'd0},
			'{OP_ADJUST, 16'd5, 16'hFFFF, 16'd0, 1, ST_NOT_LOWER, 10'd0, 11'd0},
			'{OP_INSERT, 16'h1234, 16'd100, 16'd0, 1, ST_OK, 10'd0, 11'd1},
			'{OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, ST_OK, 10'd0, 11'd2},
			'{OP_INSERT, 16'h0000, 16'd0, 16'd0, 1, ST_OK, 10'd2, 11'd3},
			'{OP_INSERT, 16'd7, 16'd100, 16'd0, 0, ST_OK, 10'd0, 11'd0},
			'{OP_INSERT, 16'd8, 16'd100, 16'd0, 0, ST_OK, 10'd0, 11'd0},
			'{OP_INSERT, 16'd9, 16'd50, 16'd0, 0, ST_OK, 10'd0, 11'd0},
			'{OP_ADJUST, 16'd8, 16'd60, 16'd100, 0, ST_OK, 10'd0, 11'd0},
			'{OP_ADJUST, 16'h1234, 16'd1, 16'd100, 0, ST_OK, 10'd0, 11'd0},
			'{OP_ADJUST, 16'd4242, 16'd40, 16'd100, 0, ST_OK, 10'd0, 11'd0},
			'{OP_ADJUST, 16'd9, 16'd0, 16'd50, 0, ST_OK, 10'd0, 11'd0},
			'{OP_ADJUST, 16'd0, 16'd0, 16'd1, 0, ST_OK, 10'd0, 11'd0},
			'{OP_ADJUST, 16'hFFFF, 16'hFFFE, 16'hFFFF, 0, ST_OK, 10'd0, 11'd0},
			'{OP_ADJUST, 16'd7, 16'd99, 16'd100, 0, ST_OK, 10'd0, 11'd0},
			'{OP_INSERT, 16'h00FF, 16'h8000, 16'h7FFF, 0, ST_OK, 10'd0, 11'd0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			typed_result = '{row.st, row.pos, row.cnt};
			send_request(row.op, row.id, row.sc, row.old, row.typed, typed_result);
		end

		// Random mix, with repeated scores to exercise the scans over equal scores.
		for (int i = 0; i < 563; i++) begin
			calm = (i >= 200 && i < 300);
			n = $urandom_range(99);
			if (shadow_count < 300 && n < 55) begin
				if (shadow_count > 0 && $urandom_range(3) == 0)
					send_request(OP_INSERT, 16'($urandom_range(65535)),
						shadow_scores[$urandom_range(shadow_count - 1)],
						16'($urandom_range(65535)), 0, unused);
				else
					send_request(OP_INSERT, 16'($urandom_range(65535)),
						16'($urandom_range(4000, 65535)), 16'($urandom_range(65535)), 0, unused);
			end else begin
				send_random_adjust();
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d inserts and %0d adjusts, %0d results checked, %0d entries held at the end.",
			inserts_sent, adjusts_sent, results_seen, shadow_count);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
